// ===== hw/rtl/min_window_reaching_sum_core_macros.svh =====
// Assertion helpers for the minimum window core.
`ifndef MIN_WINDOW_REACHING_SUM_CORE_MACROS_SVH
`define MIN_WINDOW_REACHING_SUM_CORE_MACROS_SVH

// Property must hold at every clock outside reset.
`define MWRS_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Expression must never be true outside reset.
`define MWRS_ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) else $error(msg);

`endif

// ===== hw/rtl/mwrs_pkg.sv =====
`timescale 1ns / 1ps

package mwrs_pkg;

    localparam int TARGET_W       = 26;
    localparam int MIN_LEN_W      = 11;
    localparam int DEF_MAX_LEN    = 1024;
    localparam int DEF_VALUE_BITS = 16;

    typedef struct packed {
        logic                 valid;
        logic [MIN_LEN_W-1:0] min_length;
        logic                 truncated;
    } t_result;

endpackage

// ===== hw/rtl/mwrs_if.sv =====
`timescale 1ns / 1ps

interface mwrs_in_if
    import mwrs_pkg::*;
#(
    parameter int VALUE_BITS = DEF_VALUE_BITS
) ();
    logic                  valid;
    logic                  ready;
    logic [VALUE_BITS-1:0] value;
    logic                  last;

    modport source (output valid, output value, output last, input ready);
    modport sink   (input valid, input value, input last, output ready);
endinterface

interface mwrs_out_if
    import mwrs_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [MIN_LEN_W-1:0] min_length;
    logic                 truncated;

    modport source (output valid, output min_length, output truncated, input ready);
    modport sink   (input valid, input min_length, input truncated, output ready);
endinterface

// ===== hw/rtl/mwrs_ram.sv =====
`timescale 1ns / 1ps

module mwrs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/mwrs_window.sv =====
`timescale 1ns / 1ps
`include "min_window_reaching_sum_core_macros.svh"

module mwrs_window
    import mwrs_pkg::*;
#(
    parameter int MAX_LEN    = DEF_MAX_LEN,
    parameter int VALUE_BITS = DEF_VALUE_BITS,
    parameter int ADDR_W     = $clog2(MAX_LEN)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [VALUE_BITS-1:0] i_value,
    input  logic                  i_last,
    input  logic [TARGET_W-1:0]   i_target,
    input  logic                  i_res_ready,
    output t_result               o_res,
    output logic                  o_mem_we,
    output logic [ADDR_W-1:0]     o_mem_waddr,
    output logic [VALUE_BITS-1:0] o_mem_wdata,
    output logic                  o_mem_re,
    output logic [ADDR_W-1:0]     o_mem_raddr,
    input  logic [VALUE_BITS-1:0] i_mem_rdata
);

    localparam int CNT_W   = $clog2(MAX_LEN + 1);
    localparam int RAW_W   = VALUE_BITS + CNT_W + 1;
    localparam int SUM_W   = (RAW_W > TARGET_W) ? RAW_W : TARGET_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_POP   = 3'd2;
    localparam logic [2:0] S_EVAL  = 3'd3;
    localparam logic [2:0] S_EMIT  = 3'd4;

    logic [2:0]       r_state, n_state;
    logic [CNT_W-1:0] r_head, n_head;
    logic [CNT_W-1:0] r_tail, n_tail;
    logic [SUM_W-1:0] r_total, n_total;
    logic [CNT_W-1:0] r_best, n_best;
    logic             r_ovf, n_ovf;
    logic             r_last, n_last;

    logic [CNT_W-1:0] len;
    logic [CNT_W-1:0] head_inc;
    logic [SUM_W-1:0] tgt_ext;
    logic [SUM_W-1:0] rest;

    assign len      = r_tail - r_head;
    assign head_inc = r_head + CNT_W'(1);
    assign tgt_ext  = SUM_W'(i_target);
    assign rest     = r_total - SUM_W'(i_mem_rdata);
    assign o_ready  = (r_state == S_IDLE);

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_tail      = r_tail;
        n_total     = r_total;
        n_best      = r_best;
        n_ovf       = r_ovf;
        n_last      = r_last;
        o_mem_we    = 1'b0;
        o_mem_waddr = r_tail[ADDR_W-1:0];
        o_mem_wdata = i_value;
        o_mem_re    = 1'b0;
        o_mem_raddr = r_head[ADDR_W-1:0];
        o_res.valid      = 1'b0;
        o_res.min_length = MIN_LEN_W'(r_best);
        o_res.truncated  = r_ovf;

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_last = i_last;
                    if (r_tail < CNT_W'(MAX_LEN)) begin
                        o_mem_we = 1'b1;
                        n_tail   = r_tail + CNT_W'(1);
                        n_total  = r_total + SUM_W'(i_value);
                        n_state  = S_CHECK;
                    end else begin
                        n_ovf   = 1'b1;
                        n_state = i_last ? S_EMIT : S_IDLE;
                    end
                end
            end
            S_CHECK: begin
                if (len > CNT_W'(1)) begin
                    o_mem_re = 1'b1;
                    n_state  = S_POP;
                end else begin
                    n_state = S_EVAL;
                end
            end
            S_POP: begin
                // front value is on the read port
                if (rest >= tgt_ext) begin
                    n_total = rest;
                    n_head  = head_inc;
                    if (len > CNT_W'(2)) begin
                        o_mem_re    = 1'b1;
                        o_mem_raddr = head_inc[ADDR_W-1:0];
                    end else begin
                        n_state = S_EVAL;
                    end
                end else begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                if (r_total >= tgt_ext && (r_best == '0 || len < r_best)) begin
                    n_best = len;
                end
                n_state = r_last ? S_EMIT : S_IDLE;
            end
            S_EMIT: begin
                if (i_res_ready) begin
                    o_res.valid = 1'b1;
                    n_head      = '0;
                    n_tail      = '0;
                    n_total     = '0;
                    n_best      = '0;
                    n_ovf       = 1'b0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_tail  <= '0;
            r_total <= '0;
            r_best  <= '0;
            r_ovf   <= 1'b0;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_total <= n_total;
            r_best  <= n_best;
            r_ovf   <= n_ovf;
            r_last  <= n_last;
        end
    end

    `MWRS_ASSERT(a_head_le_tail, i_clk, i_rst_n, r_head <= r_tail, "window head passed tail")
    `MWRS_ASSERT(a_tail_bound, i_clk, i_rst_n, r_tail <= CNT_W'(MAX_LEN), "tail beyond capacity")
    `MWRS_ASSERT_NEVER(a_rw_overlap, i_clk, i_rst_n, o_mem_we && o_mem_re, "read and write together")
    `MWRS_ASSERT(a_clear_after_emit, i_clk, i_rst_n, o_res.valid |=> (r_tail == '0 && r_best == '0 && !r_ovf), "state not cleared after result")

endmodule

// ===== hw/rtl/min_window_reaching_sum_core.sv =====
`timescale 1ns / 1ps
// Shortest contiguous run of a value stream whose sum reaches a target.
// Channels: i_in (sink) carries value and last; o_out (source) carries
// min_length and truncated. A transaction completes when valid and ready are
// high at a rising edge. i_cfg_we/i_cfg_wdata write target_sum; write only
// while the block is idle.
// An accepted item keeps i_in.ready low while the core passes S_CHECK and
// S_EVAL; with more than one value in the window, S_POP examines front
// values between them: each one dropped, plus the one that stays unless the
// window shrinks to a single value. Each of those reads goes through the
// single read port of the window memory (1024 x 16 by default), which sets
// the rate. Items past MAX_LEN are not stored and only set truncated. A last
// item leads to S_EMIT, which hands the result to the output register. One
// result per sequence, on its last item; min_length 0 means no run.
// Stall: the output register holds a result until taken; the core keeps
// accepting items and only waits if a second result is ready before then.
// Reset: synchronous, active low; target_sum returns to 0, the sequence state
// clears. The window memory needs no clearing pass.
module min_window_reaching_sum_core
    import mwrs_pkg::*;
#(
    parameter int MAX_LEN    = DEF_MAX_LEN,
    parameter int VALUE_BITS = DEF_VALUE_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    mwrs_in_if.sink             i_in,
    mwrs_out_if.source          o_out,
    input  logic                i_cfg_we,
    input  logic [TARGET_W-1:0] i_cfg_wdata
);

    localparam int ADDR_W = $clog2(MAX_LEN);

    logic [TARGET_W-1:0]   r_target;
    logic                  r_out_valid;
    logic [MIN_LEN_W-1:0]  r_out_len;
    logic                  r_out_trunc;

    t_result               res;
    logic                  res_ready;
    logic                  mem_we;
    logic [ADDR_W-1:0]     mem_waddr;
    logic [VALUE_BITS-1:0] mem_wdata;
    logic                  mem_re;
    logic [ADDR_W-1:0]     mem_raddr;
    logic [VALUE_BITS-1:0] mem_rdata;

    assign res_ready = !r_out_valid || o_out.ready;

    mwrs_window #(
        .MAX_LEN    (MAX_LEN),
        .VALUE_BITS (VALUE_BITS),
        .ADDR_W     (ADDR_W)
    ) u_window (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in.valid),
        .o_ready     (i_in.ready),
        .i_value     (i_in.value),
        .i_last      (i_in.last),
        .i_target    (r_target),
        .i_res_ready (res_ready),
        .o_res       (res),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_re    (mem_re),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata)
    );

    mwrs_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (MAX_LEN),
        .AW    (ADDR_W)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_target <= i_cfg_wdata;
            end
            if (res.valid) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (res.valid) begin
            r_out_len   <= res.min_length;
            r_out_trunc <= res.truncated;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.min_length = r_out_len;
    assign o_out.truncated  = r_out_trunc;

endmodule
